@@ rtl/core/assembly_text_tokenizer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the assembly text tokenizer
// Both macros expect signals named clk and rst_n in the calling scope.
// ----------------------------------------------------------------------------
`ifndef ASSEMBLY_TEXT_TOKENIZER_TOP_MACROS_SVH
`define ASSEMBLY_TEXT_TOKENIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, character codes and the mnemonic table of the tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int NUMBER_BITS_DEF   = 64;
  localparam int KW_COUNT          = 21;
  localparam int KW_WINDOW_BYTES   = 6;
  localparam int STEP_QUEUE_DEPTH  = 2;

  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_OPEN       = 8'h28;
  localparam logic [7:0] CH_CLOSE      = 8'h29;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUMBER,
    MODE_NAME,
    MODE_LABEL,
    MODE_GLOBAL,
    MODE_COMMENT
  } scan_mode_t;

  typedef enum logic [3:0] {
    KIND_NUMBER  = 4'd0,
    KIND_NAME    = 4'd1,
    KIND_KEYWORD = 4'd2,
    KIND_LABEL   = 4'd3,
    KIND_GLOBAL  = 4'd4,
    KIND_OPEN    = 4'd5,
    KIND_CLOSE   = 4'd6,
    KIND_COLON   = 4'd7,
    KIND_ERROR   = 4'd8
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [4:0]  kw_index;
    logic [63:0] number;
    logic [31:0] start;
    logic [31:0] length;
    logic        run_end;
  } token_t;

  // All tokens caused by one input byte; count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] index;
  } kw_match_t;

  // Mnemonics packed with the first character in the low byte, so each
  // string literal is written back to front.
  localparam logic [47:0] KW_TABLE [KW_COUNT] = '{
    48'("labolg"), 48'("pon"),    48'("hsupi"), 48'("hsupf"), 48'("pud"),
    48'("paws"),   48'("pop"),    48'("ter"),   48'("erots"), 48'("daol"),
    48'("gerots"), 48'("gdaol"),  48'("pmj"),   48'("zj"),    48'("znj"),
    48'("llac"),   48'("dda"),    48'("bus"),   48'("lum"),   48'("vid"),
    48'("dom")
  };

  function automatic kw_match_t kw_lookup(input logic [47:0] window);
    kw_match_t m;
    m = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!m.hit && window == KW_TABLE[k]) begin
        m.hit   = 1'b1;
        m.index = 5'(k);
      end
    end
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

@@ rtl/core/ast_in_if.sv @@
// ----------------------------------------------------------------------------
// ast_in_if
// Byte channel into the tokenizer: one source character per item.
// ----------------------------------------------------------------------------
interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

@@ rtl/core/ast_out_if.sv @@
// ----------------------------------------------------------------------------
// ast_out_if
// Token channel out of the tokenizer: one token per item.
// ----------------------------------------------------------------------------
interface ast_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [4:0]  keyword_index;
  logic [63:0] number_value;
  logic [31:0] text_start;
  logic [31:0] text_length;
  logic        run_end;

  modport source (output valid, token_kind, keyword_index, number_value, text_start,
                  text_length, run_end, input ready);
  modport sink   (input valid, token_kind, keyword_index, number_value, text_start,
                  text_length, run_end, output ready);
endinterface

@@ rtl/core/ast_scan.sv @@
// ----------------------------------------------------------------------------
// ast_scan
// Input byte register, scan state and the per-byte token logic. Each byte
// yields a step record of up to two tokens for the step queue.
// ----------------------------------------------------------------------------
module ast_scan #(
  parameter int POSITION_BITS = ast_pkg::POSITION_BITS_DEF,
  parameter int NUMBER_BITS   = ast_pkg::NUMBER_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ast_in_if.sink         in_chan,
  output logic           push_valid,
  output ast_pkg::step_t push_step,
  input  logic           push_ready
);
  import ast_pkg::*;

  `include "assembly_text_tokenizer_top_macros.svh"

  localparam int PB = POSITION_BITS;
  localparam int NB = NUMBER_BITS;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } cand_t;

  // Input register
  logic       in_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       fire;

  // Scan state
  scan_mode_t        mode_r,  mode_nxt,  mode_stp;
  logic [NB-1:0]     acc_r,   acc_nxt,   acc_stp;
  logic [PB-1:0]     start_r, start_nxt, start_stp;
  logic [PB-1:0]     pos_r,   pos_nxt;
  logic [47:0]       kw_r,    kw_nxt,    kw_stp;
  logic              long_r,  long_nxt,  long_stp;

  logic [PB-1:0] len_w;
  logic [PB-1:0] endpos_w;
  logic          restart;
  cand_t         cand_a, cand_b, cand_c;
  step_t         step_w;

  function automatic token_t make_tok(input token_kind_t kind, input logic [4:0] kwi,
                                      input logic [NB-1:0] num, input logic [PB-1:0] st,
                                      input logic [PB-1:0] ln);
    token_t t;
    t.kind     = kind;
    t.kw_index = kwi;
    t.number   = 64'(num);
    t.start    = 32'(st);
    t.length   = 32'(ln);
    t.run_end  = 1'b0;
    return t;
  endfunction

  // Token for whatever is pending in mode m, ending just before endp.
  function automatic cand_t flush_cand(input scan_mode_t m, input logic [NB-1:0] acc,
                                       input logic [47:0] kw, input logic lng,
                                       input logic [PB-1:0] st, input logic [PB-1:0] endp);
    cand_t         r;
    kw_match_t     km;
    logic [PB-1:0] ln;
    r  = '0;
    ln = endp - st;
    km = kw_lookup(kw);
    case (m)
      MODE_NUMBER: begin
        r.valid = 1'b1;
        r.tok   = make_tok(KIND_NUMBER, '0, acc, '0, '0);
      end
      MODE_NAME: begin
        r.valid = 1'b1;
        if (!lng && km.hit) begin
          r.tok = make_tok(KIND_KEYWORD, km.index, '0, st, ln);
        end else begin
          r.tok = make_tok(KIND_NAME, '0, '0, st, ln);
        end
      end
      MODE_LABEL: begin
        r.valid = 1'b1;
        r.tok   = make_tok(KIND_LABEL, '0, '0, st, ln);
      end
      MODE_GLOBAL: begin
        r.valid = 1'b1;
        r.tok   = make_tok(KIND_GLOBAL, '0, '0, st, ln);
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  assign fire          = in_valid_r && (push_ready || (step_w.count == 2'd0));
  assign in_chan.ready = !in_valid_r || fire;
  assign push_valid    = in_valid_r && (step_w.count != 2'd0);
  assign push_step     = step_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      byte_r <= in_chan.text_byte;
      last_r <= in_chan.end_of_text;
    end
  end

  assign len_w    = pos_r - start_r;
  assign endpos_w = pos_r + PB'(1);

  // Scan of the registered byte against the current mode.
  always_comb begin
    mode_stp  = mode_r;
    acc_stp   = acc_r;
    start_stp = start_r;
    kw_stp    = kw_r;
    long_stp  = long_r;
    cand_a    = '0;
    cand_b    = '0;
    restart   = 1'b0;

    case (mode_r)
      MODE_NUMBER: begin
        if (is_digit(byte_r)) begin
          acc_stp = (acc_r << 3) + (acc_r << 1) + NB'(byte_r[3:0]);
        end else begin
          cand_a  = flush_cand(mode_r, acc_r, kw_r, long_r, start_r, pos_r);
          restart = 1'b1;
        end
      end
      MODE_NAME: begin
        if (is_name_char(byte_r)) begin
          if (!long_r && (len_w < PB'(KW_WINDOW_BYTES))) begin
            for (int i = 0; i < KW_WINDOW_BYTES; i++) begin
              if (len_w == PB'(i)) begin
                kw_stp[8*i +: 8] = kw_r[8*i +: 8] | byte_r;
              end
            end
          end else begin
            long_stp = 1'b1;
          end
        end else begin
          cand_a  = flush_cand(mode_r, acc_r, kw_r, long_r, start_r, pos_r);
          restart = 1'b1;
        end
      end
      MODE_LABEL, MODE_GLOBAL: begin
        if ((len_w == '0) && is_digit(byte_r)) begin
          // A prefix directly followed by a digit is an error; the digit
          // then opens a number.
          cand_a.valid = 1'b1;
          cand_a.tok   = make_tok(KIND_ERROR, '0, '0, '0, '0);
          restart      = 1'b1;
        end else if (!is_name_char(byte_r)) begin
          cand_a  = flush_cand(mode_r, acc_r, kw_r, long_r, start_r, pos_r);
          restart = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (byte_r == CH_NEWLINE) begin
          mode_stp = MODE_IDLE;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    if (restart) begin
      mode_stp = MODE_IDLE;
      if (is_space(byte_r)) begin
        mode_stp = MODE_IDLE;
      end else if (byte_r == CH_SEMI) begin
        mode_stp = MODE_COMMENT;
      end else if (is_digit(byte_r)) begin
        mode_stp = MODE_NUMBER;
        acc_stp  = NB'(byte_r[3:0]);
      end else if (is_name_char(byte_r)) begin
        mode_stp  = MODE_NAME;
        start_stp = pos_r;
        kw_stp    = {40'b0, byte_r};
        long_stp  = 1'b0;
      end else if (byte_r == CH_DOT) begin
        mode_stp  = MODE_LABEL;
        start_stp = endpos_w;
      end else if (byte_r == CH_PERCENT) begin
        mode_stp  = MODE_GLOBAL;
        start_stp = endpos_w;
      end else if (byte_r == CH_OPEN) begin
        cand_b.valid = 1'b1;
        cand_b.tok   = make_tok(KIND_OPEN, '0, '0, '0, '0);
      end else if (byte_r == CH_CLOSE) begin
        cand_b.valid = 1'b1;
        cand_b.tok   = make_tok(KIND_CLOSE, '0, '0, '0, '0);
      end else if (byte_r == CH_COLON) begin
        cand_b.valid = 1'b1;
        cand_b.tok   = make_tok(KIND_COLON, '0, '0, '0, '0);
      end else begin
        cand_b.valid = 1'b1;
        cand_b.tok   = make_tok(KIND_ERROR, '0, '0, '0, '0);
      end
    end
  end

  // End of text: flush what is left and restart the scan from position zero.
  always_comb begin
    cand_c    = '0;
    mode_nxt  = mode_stp;
    acc_nxt   = acc_stp;
    start_nxt = start_stp;
    kw_nxt    = kw_stp;
    long_nxt  = long_stp;
    pos_nxt   = endpos_w;
    if (last_r) begin
      if (((mode_stp == MODE_LABEL) || (mode_stp == MODE_GLOBAL)) &&
          (endpos_w == start_stp)) begin
        // A bare prefix as the final byte.
        cand_c.valid = 1'b1;
        cand_c.tok   = make_tok(KIND_ERROR, '0, '0, '0, '0);
      end else begin
        cand_c = flush_cand(mode_stp, acc_stp, kw_stp, long_stp, start_stp, endpos_w);
      end
      mode_nxt  = MODE_IDLE;
      acc_nxt   = '0;
      start_nxt = '0;
      kw_nxt    = '0;
      long_nxt  = 1'b0;
      pos_nxt   = '0;
    end
  end

  // At most two of the three candidates are ever valid; pack them in order.
  always_comb begin
    step_w = '0;
    if (cand_a.valid) begin
      step_w.tok0 = cand_a.tok;
      step_w.tok1 = cand_b.valid ? cand_b.tok : cand_c.tok;
    end else if (cand_b.valid) begin
      step_w.tok0 = cand_b.tok;
      step_w.tok1 = cand_c.tok;
    end else begin
      step_w.tok0 = cand_c.tok;
      step_w.tok1 = '0;
    end
    step_w.count = 2'({1'b0, cand_a.valid}) + 2'({1'b0, cand_b.valid})
                 + 2'({1'b0, cand_c.valid});
    if (step_w.count == 2'd2) begin
      step_w.tok1.run_end = 1'b1;
    end else begin
      step_w.tok0.run_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      acc_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      kw_r    <= '0;
      long_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      kw_r    <= kw_nxt;
      long_r  <= long_nxt;
    end
  end

  `AST_ASSERT_NEXT(a_eot_restart, fire && last_r, (mode_r == MODE_IDLE) && (pos_r == '0), "scan state not cleared after end of text")
  `AST_ASSERT_IMPL(a_two_tokens_max, in_valid_r, !(cand_a.valid && cand_b.valid && cand_c.valid), "more than two tokens from one byte")
  `AST_ASSERT_NEXT(a_byte_held, in_valid_r && !fire, in_valid_r && $stable(byte_r), "stalled byte lost")

endmodule

@@ rtl/core/ast_tokq.sv @@
// ----------------------------------------------------------------------------
// ast_tokq
// Queue of step records; hands their tokens out one item at a time.
// ----------------------------------------------------------------------------
module ast_tokq #(
  parameter int DEPTH = ast_pkg::STEP_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  ast_pkg::step_t push_step,
  output logic           push_ready,
  ast_out_if.source      out_chan
);
  import ast_pkg::*;

  `include "assembly_text_tokenizer_top_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  step_t         mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          sub_r, sub_nxt;

  step_t  head;
  token_t tok;
  logic   last_tok;
  logic   pop_tok;
  logic   pop_step;
  logic   push;

  assign head     = mem_r[rd_r];
  assign tok      = sub_r ? head.tok1 : head.tok0;
  assign last_tok = (head.count == 2'd1) || sub_r;

  assign out_chan.valid         = (count_r != '0);
  assign out_chan.token_kind    = tok.kind;
  assign out_chan.keyword_index = tok.kw_index;
  assign out_chan.number_value  = tok.number;
  assign out_chan.text_start    = tok.start;
  assign out_chan.text_length   = tok.length;
  assign out_chan.run_end       = tok.run_end;

  assign pop_tok    = out_chan.valid && out_chan.ready;
  assign pop_step   = pop_tok && last_tok;
  assign push_ready = (count_r != CW'(DEPTH)) || pop_step;
  assign push       = push_valid && push_ready;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    sub_nxt   = sub_r;
    count_nxt = count_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
    end
    if (pop_tok) begin
      sub_nxt = !last_tok;
    end
    if (pop_step) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
    if (push && !pop_step) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && pop_step) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      sub_r   <= 1'b0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      sub_r   <= sub_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_step;
    end
  end

  `AST_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(DEPTH), "step queue overfilled")
  `AST_ASSERT_IMPL(a_run_end_last, out_chan.valid, out_chan.run_end == last_tok, "run_end not on the last token of a byte")
  `AST_ASSERT_IMPL(a_head_nonempty, out_chan.valid, head.count != 2'd0, "empty step record in queue")

endmodule

@@ rtl/core/assembly_text_tokenizer_top.sv @@
// ----------------------------------------------------------------------------
// assembly_text_tokenizer_top
// Byte-serial tokenizer for stack-machine assembly text.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle and emits tokens one per cycle
// while the output accepts them. A byte enters an input register; its scan
// is combinational on that register, and when the byte is consumed the scan
// state is updated and its tokens (zero, one or two) land together in a
// two-entry step queue, which can hold the byte back while it is full. The
// first token is shown from the head of that queue once written. Bytes that
// produce at most one token stream at one per cycle while the output accepts
// them; a byte that produces two tokens occupies the output for both of them,
// which is what sets the input rate over such stretches. Name, label and
// global text is reported as start position and length; run_end marks the
// last token caused by a byte. End of text flushes the pending token and restarts positions at zero.
module assembly_text_tokenizer_top #(
  parameter int POSITION_BITS = ast_pkg::POSITION_BITS_DEF,
  parameter int NUMBER_BITS   = ast_pkg::NUMBER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ast_in_if.sink    in_chan,
  ast_out_if.source out_chan
);
  import ast_pkg::*;

  logic  push_valid;
  logic  push_ready;
  step_t push_step;

  ast_scan #(
    .POSITION_BITS (POSITION_BITS),
    .NUMBER_BITS   (NUMBER_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_step  (push_step),
    .push_ready (push_ready)
  );

  ast_tokq #(
    .DEPTH (STEP_QUEUE_DEPTH)
  ) u_tokq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_step  (push_step),
    .push_ready (push_ready),
    .out_chan   (out_chan)
  );

endmodule
